// ===== hw/rtl/ttcd_pkg.sv =====
// ttcd_pkg: shared constants, codes and command/status types of the tap detector
// used by the channel interfaces, the controller, the datapath and the top level
package ttcd_pkg;

  localparam int SCREEN_WIDTH_DEF  = 480;
  localparam int SCREEN_HEIGHT_DEF = 320;

  localparam int MODE_W     = 2;
  localparam int VAL_W      = 16;
  localparam int RES_W      = 9;
  localparam int TICK_W     = 32;
  localparam int CELL_W     = 8;
  localparam int INV_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_TOUCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_X     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_Y     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_FLAGS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HOLD     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT  = 3'd7;

  localparam logic [VAL_W-1:0]  RST_AXIS_MIN = 16'd0;
  localparam logic [VAL_W-1:0]  RST_AXIS_MAX = 16'd4095;
  localparam logic [TICK_W-1:0] RST_MIN_HOLD = 32'd10;
  localparam logic [CELL_W-1:0] RST_CELL_W   = 8'd8;
  localparam logic [CELL_W-1:0] RST_CELL_H   = 8'd16;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef struct packed {
    logic take;
    logic axis;
    logic ld_inv;
    logic ld_off;
    logic ld_mul;
    logic div_start_rng;
    logic div_start_cell;
    logic div_step;
    logic store_res;
    logic out_load;
    logic clear_state;
  } ttcd_cmd_t;

  typedef struct packed {
    logic release_evt;
    logic tap_ok;
    logic div_done;
    logic out_busy;
  } ttcd_sts_t;

endpackage

// ===== hw/rtl/ttcd_in_if.sv =====
// ttcd_in_if: touch event channel, valid/ready with mode and event value
// depends on ttcd_pkg for field widths
interface ttcd_in_if;
  logic                         valid;
  logic                         ready;
  logic [ttcd_pkg::MODE_W-1:0] mode;
  logic [ttcd_pkg::VAL_W-1:0]  event_value;

  modport source (output valid, output mode, output event_value, input ready);
  modport sink   (input valid, input mode, input event_value, output ready);
endinterface

// ===== hw/rtl/ttcd_out_if.sv =====
// ttcd_out_if: tap result channel, valid/ready with text column and row
// depends on ttcd_pkg for field widths
interface ttcd_out_if;
  logic                        valid;
  logic                        ready;
  logic [ttcd_pkg::RES_W-1:0] tap_column;
  logic [ttcd_pkg::RES_W-1:0] tap_row;

  modport source (output valid, output tap_column, output tap_row, input ready);
  modport sink   (input valid, input tap_column, input tap_row, output ready);
endinterface

// ===== hw/rtl/ttcd_ctrl.sv =====
// ttcd_ctrl: sequencer for event intake and the per-axis tap conversion
// depends on ttcd_pkg for command and status types
module ttcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ttcd_pkg::ttcd_sts_t sts,
  output ttcd_pkg::ttcd_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_INV    = 4'd2;
  localparam logic [3:0] ST_OFF    = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_DRS    = 4'd5;
  localparam logic [3:0] ST_DRUN_R = 4'd6;
  localparam logic [3:0] ST_DCS    = 4'd7;
  localparam logic [3:0] ST_DRUN_C = 4'd8;
  localparam logic [3:0] ST_STORE  = 4'd9;
  localparam logic [3:0] ST_FIN    = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= ttcd_pkg::AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.axis  = axis_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        axis_nxt = ttcd_pkg::AXIS_X;
        if (in_valid && sts.release_evt) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.tap_ok ? ST_INV : ST_IDLE;
      end
      ST_INV: begin
        cmd.ld_inv = 1'b1;
        state_nxt  = ST_OFF;
      end
      ST_OFF: begin
        cmd.ld_off = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        cmd.ld_mul = 1'b1;
        state_nxt  = ST_DRS;
      end
      ST_DRS: begin
        cmd.div_start_rng = 1'b1;
        state_nxt         = ST_DRUN_R;
      end
      ST_DRUN_R: begin
        if (sts.div_done) begin
          state_nxt = ST_DCS;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DCS: begin
        cmd.div_start_cell = 1'b1;
        state_nxt          = ST_DRUN_C;
      end
      ST_DRUN_C: begin
        if (sts.div_done) begin
          state_nxt = ST_STORE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_STORE: begin
        cmd.store_res = 1'b1;
        if (axis_r == ttcd_pkg::AXIS_X) begin
          axis_nxt  = ttcd_pkg::AXIS_Y;
          state_nxt = ST_INV;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load    = 1'b1;
          cmd.clear_state = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ttcd_dp.sv =====
// ttcd_dp: configuration and touch state registers, tap test, scaling multiplier,
// shared restoring divider and result register; depends on ttcd_pkg
module ttcd_dp #(
  parameter int SCREEN_WIDTH  = ttcd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttcd_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ttcd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ttcd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [ttcd_pkg::MODE_W-1:0]         in_mode,
  input  logic [ttcd_pkg::VAL_W-1:0]          in_event_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ttcd_pkg::RES_W-1:0]          out_tap_column,
  output logic [ttcd_pkg::RES_W-1:0]          out_tap_row,
  input  ttcd_pkg::ttcd_cmd_t                 cmd,
  output ttcd_pkg::ttcd_sts_t                 sts
);

  localparam int PIX_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int PW      = $clog2(PIX_MAX + 1);
  localparam int VW      = ttcd_pkg::VAL_W;
  localparam int DW      = VW + PW;
  localparam int CW      = $clog2(DW + 1);
  localparam int RW      = ttcd_pkg::RES_W;

  // configuration
  logic [VW-1:0]                   x_min_r, x_max_r, y_min_r, y_max_r;
  logic [ttcd_pkg::INV_W-1:0]      inv_r;
  logic [ttcd_pkg::TICK_W-1:0]     min_hold_r;
  logic [ttcd_pkg::CELL_W-1:0]     cell_w_r, cell_h_r;

  // touch state
  logic [VW-1:0]                   cur_x_r, cur_y_r, press_x_r, press_y_r;
  logic [ttcd_pkg::TICK_W-1:0]     held_r;

  // conversion
  logic [VW-1:0]                   work_r;
  logic [DW-1:0]                   prod_r;
  logic [DW-1:0]                   quo_r, quo_nxt;
  logic [VW-1:0]                   rem_r, rem_nxt;
  logic [VW-1:0]                   dvs_r;
  logic [CW-1:0]                   cnt_r;
  logic [RW-1:0]                   col_r, row_r;
  logic                            out_valid_r;
  logic [RW-1:0]                   out_col_r, out_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= ttcd_pkg::RST_AXIS_MIN;
      x_max_r    <= ttcd_pkg::RST_AXIS_MAX;
      y_min_r    <= ttcd_pkg::RST_AXIS_MIN;
      y_max_r    <= ttcd_pkg::RST_AXIS_MAX;
      inv_r      <= '0;
      min_hold_r <= ttcd_pkg::RST_MIN_HOLD;
      cell_w_r   <= ttcd_pkg::RST_CELL_W;
      cell_h_r   <= ttcd_pkg::RST_CELL_H;
    end else if (cfg_we) begin
      case (cfg_idx)
        ttcd_pkg::REG_AXIS_X_MIN:   x_min_r    <= cfg_data[VW-1:0];
        ttcd_pkg::REG_AXIS_X_MAX:   x_max_r    <= cfg_data[VW-1:0];
        ttcd_pkg::REG_AXIS_Y_MIN:   y_min_r    <= cfg_data[VW-1:0];
        ttcd_pkg::REG_AXIS_Y_MAX:   y_max_r    <= cfg_data[VW-1:0];
        ttcd_pkg::REG_INVERT_FLAGS: inv_r      <= cfg_data[ttcd_pkg::INV_W-1:0];
        ttcd_pkg::REG_MIN_HOLD:     min_hold_r <= cfg_data[ttcd_pkg::TICK_W-1:0];
        ttcd_pkg::REG_CELL_WIDTH:   cell_w_r   <= cfg_data[ttcd_pkg::CELL_W-1:0];
        ttcd_pkg::REG_CELL_HEIGHT:  cell_h_r   <= cfg_data[ttcd_pkg::CELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // event intake
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_state) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      press_x_r <= '0;
      press_y_r <= '0;
      held_r    <= '0;
    end else if (cmd.take) begin
      case (in_mode)
        ttcd_pkg::MODE_TOUCH: begin
          if (in_event_value != '0) begin
            press_x_r <= cur_x_r;
            press_y_r <= cur_y_r;
            held_r    <= '0;
          end
        end
        ttcd_pkg::MODE_X: cur_x_r <= in_event_value;
        ttcd_pkg::MODE_Y: cur_y_r <= in_event_value;
        ttcd_pkg::MODE_TICK: begin
          if (held_r != '1) begin
            held_r <= held_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tap test
  logic [VW-1:0]   rng_x, rng_y, dx, dy;
  logic [VW+3:0]   dx10, dy10;

  assign rng_x = (x_max_r > x_min_r) ? x_max_r - x_min_r : '0;
  assign rng_y = (y_max_r > y_min_r) ? y_max_r - y_min_r : '0;
  assign dx    = (cur_x_r >= press_x_r) ? cur_x_r - press_x_r : press_x_r - cur_x_r;
  assign dy    = (cur_y_r >= press_y_r) ? cur_y_r - press_y_r : press_y_r - cur_y_r;
  assign dx10  = {1'b0, dx, 3'b000} + {3'b000, dx, 1'b0};
  assign dy10  = {1'b0, dy, 3'b000} + {3'b000, dy, 1'b0};

  assign sts.release_evt = (in_mode == ttcd_pkg::MODE_TOUCH) && (in_event_value == '0);
  assign sts.tap_ok      = (held_r > min_hold_r) &&
                           (dx10 < {4'b0000, rng_x}) && (dy10 < {4'b0000, rng_y});
  assign sts.div_done    = (cnt_r == '0);
  assign sts.out_busy    = out_valid_r && !out_ready;

  // axis selection
  logic                        a_inv;
  logic [VW-1:0]               a_val, a_lo, a_hi, a_rng;
  logic [PW-1:0]               a_pix;
  logic [ttcd_pkg::CELL_W-1:0] a_cell;

  always_comb begin
    if (cmd.axis == ttcd_pkg::AXIS_Y) begin
      a_inv  = inv_r[1];
      a_val  = cur_y_r;
      a_lo   = y_min_r;
      a_hi   = y_max_r;
      a_rng  = rng_y;
      a_pix  = PW'(SCREEN_HEIGHT);
      a_cell = cell_h_r;
    end else begin
      a_inv  = inv_r[0];
      a_val  = cur_x_r;
      a_lo   = x_min_r;
      a_hi   = x_max_r;
      a_rng  = rng_x;
      a_pix  = PW'(SCREEN_WIDTH);
      a_cell = cell_w_r;
    end
  end

  // inversion, offset with clamp, scaling
  always_ff @(posedge clk) begin
    if (cmd.ld_inv) begin
      if (a_inv) begin
        work_r <= (a_hi >= a_val) ? a_hi - a_val : '0;
      end else begin
        work_r <= a_val;
      end
    end else if (cmd.ld_off) begin
      if (work_r <= a_lo) begin
        work_r <= '0;
      end else if (work_r - a_lo > a_rng) begin
        work_r <= a_rng;
      end else begin
        work_r <= work_r - a_lo;
      end
    end
    if (cmd.ld_mul) begin
      prod_r <= DW'(work_r) * DW'(a_pix);
    end
  end

  // restoring divider, one quotient bit per step
  logic [VW:0] trial;
  logic        ge;

  assign trial = {rem_r, quo_r[DW-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt = {quo_r[DW-2:0], ge};
    rem_nxt = ge ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.div_start_rng) begin
      cnt_r <= CW'(DW);
    end else if (cmd.div_start_cell) begin
      cnt_r <= CW'(PW);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start_rng) begin
      quo_r <= prod_r;
      rem_r <= '0;
      dvs_r <= a_rng;
    end else if (cmd.div_start_cell) begin
      quo_r <= {quo_r[PW-1:0], {VW{1'b0}}};
      rem_r <= '0;
      dvs_r <= {{(VW - ttcd_pkg::CELL_W){1'b0}}, (a_cell == '0) ? 8'd1 : a_cell};
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // result
  logic [PW+RW-1:0] res_ext;

  assign res_ext = {{RW{1'b0}}, quo_r[PW-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.store_res) begin
      if (cmd.axis == ttcd_pkg::AXIS_Y) begin
        row_r <= res_ext[RW-1:0];
      end else begin
        col_r <= res_ext[RW-1:0];
      end
    end
    if (cmd.out_load) begin
      out_col_r <= col_r;
      out_row_r <= row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tap_column = out_col_r;
  assign out_tap_row    = out_row_r;

endmodule

// ===== hw/rtl/touch_tap_to_cell_detector.sv =====
// touch_tap_to_cell_detector: touch events in, tap text cell out
// press, sample and tick events are taken while idle; a release that is no tap goes back to
// idle after the tap test; a tapping release runs inversion, offset, scaling and two divisions
// per axis on the shared one-bit-per-cycle divider, then loads the result; intake reopens
// after the load, later still while an older result waits; synchronous active-low
// reset restores register defaults and clears touch state; depends on ttcd_pkg and blocks
module touch_tap_to_cell_detector #(
  parameter int SCREEN_WIDTH  = ttcd_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttcd_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ttcd_in_if.sink                         in_ch,
  ttcd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ttcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ttcd_pkg::CFG_DATA_W-1:0] cfg_data
);

  ttcd_pkg::ttcd_cmd_t cmd;
  ttcd_pkg::ttcd_sts_t sts;
  logic                in_ready;

  ttcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ttcd_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_mode        (in_ch.mode),
    .in_event_value (in_ch.event_value),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_tap_column (out_ch.tap_column),
    .out_tap_row    (out_ch.tap_row),
    .cmd            (cmd),
    .sts            (sts)
  );

  assign in_ch.ready = in_ready;

  a_release_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && sts.release_evt) |=> !in_ch.ready)
    else $error("intake open after release transfer");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_ch.valid)
    else $error("result not presented after load");

  a_clear_no_tap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_state |=> !sts.tap_ok)
    else $error("tap condition survives clear");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_start_rng || cmd.div_start_cell) |=> !sts.div_done)
    else $error("divider idle after start");

endmodule

// ===== tb/sv/ttcd_tap_checker.sv =====
// ttcd_tap_checker: watches the event, result and register ports of the tap detector,
// predicts the tap cell for every release that is a tap and compares each result transfer in order
// depends on ttcd_pkg, ttcd_in_if and ttcd_out_if
module ttcd_tap_checker
  import ttcd_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ttcd_in_if                    in_mon,
  ttcd_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    waiting,
  output int                    fail_total
);

  typedef struct packed {
    logic [RES_W-1:0] column;
    logic [RES_W-1:0] row;
  } tap_cell_t;

  tap_cell_t tap_queue[$];
  int        mismatches = 0;

  logic [VAL_W-1:0]  x_lo, x_hi, y_lo, y_hi;
  logic [INV_W-1:0]  flip;
  logic [TICK_W-1:0] hold_min;
  logic [CELL_W-1:0] cell_w, cell_h;

  logic [VAL_W-1:0]  pos_x, pos_y, anchor_x, anchor_y;
  logic [TICK_W-1:0] hold_count;

  function automatic logic [VAL_W-1:0] axis_span(input logic [VAL_W-1:0] lo, hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  function automatic bit still(input logic [VAL_W-1:0] now, mark, extent);
    longint unsigned gap;
    gap = (now >= mark) ? now - mark : mark - now;
    return (10 * gap) < extent;
  endfunction

  function automatic logic [RES_W-1:0] text_cell(input logic [VAL_W-1:0] sample,
                                                 input logic mirror,
                                                 input logic [VAL_W-1:0] lo, hi,
                                                 input int unsigned pixels,
                                                 input logic [CELL_W-1:0] pitch);
    logic [VAL_W-1:0] pos;
    longint unsigned  extent, offset, px, divisor, quotient;
    pos = sample;
    if (mirror) pos = (hi >= sample) ? hi - sample : '0;
    extent = axis_span(lo, hi);
    offset = (pos > lo) ? pos - lo : 0;
    if (offset > extent) offset = extent;
    px = (extent != 0) ? (offset * pixels) / extent : 0;
    divisor = (pitch == '0) ? 1 : pitch;
    quotient = px / divisor;
    return quotient[RES_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t tap mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic clear_touch();
    pos_x      = '0;
    pos_y      = '0;
    anchor_x   = '0;
    anchor_y   = '0;
    hold_count = '0;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_AXIS_X_MIN:   x_lo = data[VAL_W-1:0];
      REG_AXIS_X_MAX:   x_hi = data[VAL_W-1:0];
      REG_AXIS_Y_MIN:   y_lo = data[VAL_W-1:0];
      REG_AXIS_Y_MAX:   y_hi = data[VAL_W-1:0];
      REG_INVERT_FLAGS: flip = data[INV_W-1:0];
      REG_MIN_HOLD:     hold_min = data[TICK_W-1:0];
      REG_CELL_WIDTH:   cell_w = data[CELL_W-1:0];
      REG_CELL_HEIGHT:  cell_h = data[CELL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic track_event(input logic [MODE_W-1:0] mode, input logic [VAL_W-1:0] value);
    tap_cell_t hit;
    case (mode)
      MODE_X: pos_x = value;
      MODE_Y: pos_y = value;
      MODE_TICK: if (hold_count != '1) hold_count = hold_count + 1'b1;
      MODE_TOUCH: begin
        if (value != '0) begin
          anchor_x   = pos_x;
          anchor_y   = pos_y;
          hold_count = '0;
        end else if (hold_count > hold_min &&
                     still(pos_x, anchor_x, axis_span(x_lo, x_hi)) &&
                     still(pos_y, anchor_y, axis_span(y_lo, y_hi))) begin
          hit.column = text_cell(pos_x, flip[0], x_lo, x_hi, SCREEN_WIDTH, cell_w);
          hit.row    = text_cell(pos_y, flip[1], y_lo, y_hi, SCREEN_HEIGHT, cell_h);
          tap_queue.push_back(hit);
          clear_touch();
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_tap(input logic [RES_W-1:0] col, row);
    tap_cell_t want;
    if (tap_queue.size() == 0) begin
      report_mismatch($sformatf("column %0d row %0d with no tap due", col, row));
    end else begin
      want = tap_queue.pop_front();
      if (col !== want.column)
        report_mismatch($sformatf("column %0d, want %0d", col, want.column));
      if (row !== want.row)
        report_mismatch($sformatf("row %0d, want %0d", row, want.row));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      x_lo     = RST_AXIS_MIN;
      x_hi     = RST_AXIS_MAX;
      y_lo     = RST_AXIS_MIN;
      y_hi     = RST_AXIS_MAX;
      flip     = '0;
      hold_min = RST_MIN_HOLD;
      cell_w   = RST_CELL_W;
      cell_h   = RST_CELL_H;
      clear_touch();
      tap_queue.delete();
    end else begin
      if (cfg_we) apply_write(cfg_idx, cfg_data);
      if (out_mon.valid && out_mon.ready) check_tap(out_mon.tap_column, out_mon.tap_row);
      if (in_mon.valid && in_mon.ready) track_event(in_mon.mode, in_mon.event_value);
    end
    waiting    <= tap_queue.size();
    fail_total <= mismatches;
  end

endmodule

// ===== tb/sv/touch_tap_to_cell_detector_tb.sv =====
// touch_tap_to_cell_detector_tb: drives touch gestures, noise and register settings
// into the tap detector under varying idle and stall, verdict from ttcd_tap_checker
// depends on ttcd_pkg, ttcd_in_if, ttcd_out_if, ttcd_tap_checker and the detector
module touch_tap_to_cell_detector_tb;
  import ttcd_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    waiting;
  int                    fail_total;

  int unsigned sent = 0;
  int unsigned send_idle = 0;
  int unsigned stall_pct = 0;
  int unsigned phase_len [8] = '{220, 200, 230, 230, 80, 60, 200, 220};

  logic [VAL_W-1:0]  x_lo, x_hi, y_lo, y_hi;
  logic [TICK_W-1:0] hold_min;

  ttcd_in_if  in_bus();
  ttcd_out_if out_bus();

  touch_tap_to_cell_detector uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_bus),
    .out_ch   (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  ttcd_tap_checker tap_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .waiting    (waiting),
    .fail_total (fail_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [VAL_W-1:0] pick_sample(input logic [VAL_W-1:0] lo, hi);
    if (hi > lo && $urandom_range(9) != 0) return VAL_W'($urandom_range(hi, lo));
    return VAL_W'($urandom_range(65535));
  endfunction

  // moves a sample by less than a tenth of the span, now and then by exactly the limit
  function automatic logic [VAL_W-1:0] nudge(input logic [VAL_W-1:0] base,
                                             input int unsigned extent);
    int unsigned d;
    if (extent == 0) d = $urandom_range(3);
    else if ($urandom_range(4) == 0) d = (extent + 9) / 10;
    else d = $urandom_range((extent - 1) / 10);
    if (($urandom_range(1) == 0 && base >= d) || base + d > 65535) return VAL_W'(base - d);
    return VAL_W'(base + d);
  endfunction

  task automatic send_event(input logic [MODE_W-1:0] m, input logic [VAL_W-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.mode        <= m;
    in_bus.event_value <= v;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value,
                           input int unsigned bits);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom();
    if (bits < CFG_DATA_W) junk = junk << bits;
    else junk = '0;
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= junk | value;
    @(posedge clk);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic apply_setup(input int p);
    logic [VAL_W-1:0]  a, b, c, d;
    logic [INV_W-1:0]  inv;
    logic [TICK_W-1:0] hold;
    logic [CELL_W-1:0] cw, ch;
    case (p)
      1: begin
        a = '0; b = '1; c = '0; d = '1; inv = 2'b11; hold = '0; cw = 8'd1; ch = 8'd1;
      end
      4: begin
        a = 16'd5000; b = 16'd5000; c = 16'd3000; d = 16'd1200;
        inv = 2'b00; hold = 32'd2; cw = 8'd8; ch = 8'd8;
      end
      5: begin
        a = 16'd100; b = '1; c = 16'd4000; d = 16'd60000;
        inv = 2'b01; hold = '1; cw = 8'd255; ch = 8'd255;
      end
      6: begin
        a = 16'd10; b = 16'd19; c = 16'd65534; d = 16'd65535;
        inv = 2'b10; hold = 32'd1; cw = '0; ch = '0;
      end
      default: begin
        a = VAL_W'($urandom_range(30000));
        b = a + VAL_W'($urandom_range(35535, 1));
        c = VAL_W'($urandom_range(30000));
        d = c + VAL_W'($urandom_range(35535, 1));
        inv = INV_W'($urandom_range(3));
        hold = TICK_W'($urandom_range(6));
        cw = CELL_W'($urandom_range(255, 1));
        ch = CELL_W'($urandom_range(255, 1));
      end
    endcase
    write_reg(REG_AXIS_X_MIN, CFG_DATA_W'(a), VAL_W);
    write_reg(REG_AXIS_X_MAX, CFG_DATA_W'(b), VAL_W);
    write_reg(REG_AXIS_Y_MIN, CFG_DATA_W'(c), VAL_W);
    write_reg(REG_AXIS_Y_MAX, CFG_DATA_W'(d), VAL_W);
    write_reg(REG_INVERT_FLAGS, CFG_DATA_W'(inv), INV_W);
    write_reg(REG_MIN_HOLD, CFG_DATA_W'(hold), TICK_W);
    write_reg(REG_CELL_WIDTH, CFG_DATA_W'(cw), CELL_W);
    write_reg(REG_CELL_HEIGHT, CFG_DATA_W'(ch), CELL_W);
    cfg_we <= 1'b0;
    x_lo = a;
    x_hi = b;
    y_lo = c;
    y_hi = d;
    hold_min = hold;
  endtask

  // position, press, hold, small drift, release
  task automatic run_gesture();
    logic [VAL_W-1:0] bx, by;
    int unsigned      ticks, rx, ry;
    rx = (x_hi > x_lo) ? x_hi - x_lo : 0;
    ry = (y_hi > y_lo) ? y_hi - y_lo : 0;
    bx = pick_sample(x_lo, x_hi);
    by = pick_sample(y_lo, y_hi);
    send_event(MODE_X, bx);
    send_event(MODE_Y, by);
    send_event(MODE_TOUCH, VAL_W'($urandom_range(65535, 1)));
    if ($urandom_range(9) == 0) send_event(MODE_TOUCH, VAL_W'($urandom_range(65535, 1)));
    if (hold_min < 40) begin
      if ($urandom_range(6) == 0) ticks = $urandom_range(hold_min);
      else ticks = hold_min + 1 + $urandom_range(3);
    end else begin
      ticks = $urandom_range(20);
    end
    repeat (ticks) send_event(MODE_TICK, VAL_W'($urandom_range(65535)));
    if ($urandom_range(2) == 0) send_event(MODE_X, nudge(bx, rx));
    if ($urandom_range(2) == 0) send_event(MODE_Y, nudge(by, ry));
    send_event(MODE_TOUCH, '0);
  endtask

  task automatic noise_burst();
    logic [MODE_W-1:0] m;
    logic [VAL_W-1:0]  v;
    repeat ($urandom_range(6, 1)) begin
      m = MODE_W'($urandom_range(3));
      v = VAL_W'($urandom_range(65535));
      if (m == MODE_TOUCH && $urandom_range(1) == 0) v = '0;
      send_event(m, v);
    end
  endtask

  initial begin
    int unsigned limit;
    int unsigned guard;
    in_bus.valid       = 1'b0;
    in_bus.mode        = MODE_TICK;
    in_bus.event_value = '0;
    cfg_we             = 1'b0;
    cfg_idx            = REG_AXIS_X_MIN;
    cfg_data           = '0;
    rst_n              = 1'b0;
    x_lo               = RST_AXIS_MIN;
    x_hi               = RST_AXIS_MAX;
    y_lo               = RST_AXIS_MIN;
    y_hi               = RST_AXIS_MAX;
    hold_min           = RST_MIN_HOLD;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // ticks before any press, then a release with no press
    repeat (11) send_event(MODE_TICK, '0);
    send_event(MODE_X, 16'd100);
    send_event(MODE_Y, 16'd200);
    send_event(MODE_TOUCH, '0);
    // beyond the axis range, press twice, too short a hold
    send_event(MODE_X, '1);
    send_event(MODE_Y, '1);
    send_event(MODE_TOUCH, '1);
    send_event(MODE_TOUCH, 16'd1);
    repeat (3) send_event(MODE_TICK, '1);
    send_event(MODE_TOUCH, '0);
    send_event(MODE_X, '0);
    send_event(MODE_Y, '0);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        settle();
        apply_setup(p);
      end
      case (p % 4)
        0: begin send_idle = 0;  stall_pct <= 0;  end
        1: begin send_idle = 57; stall_pct <= 0;  end
        2: begin send_idle = 0;  stall_pct <= 57; end
        default: begin send_idle = 7; stall_pct <= 7; end
      endcase
      limit = sent + phase_len[p];
      while (sent < limit) begin
        if ($urandom_range(3) != 0) run_gesture();
        else noise_burst();
      end
    end

    in_bus.valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (waiting != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (150) @(posedge clk);
    if (fail_total == 0 && waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
